// File: rtl/slpl_pkg.sv
// Shared package for the stereo lookahead peak limiter.
// Holds payload structs, the queue entry struct, register indexes and constants.
package slpl_pkg;

  localparam int unsigned DelayDepthDefault = 1024;
  localparam int unsigned SampleWidth = 24;
  localparam int unsigned GainWidth = 24;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 24;

  localparam logic [GainWidth-1:0] UnityGain = 24'd8388608;
  localparam logic [23:0] ReleaseReset = 24'd3495;

  localparam logic [CfgIndexWidth-1:0] RegCeiling = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegLookahead = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegRelease = 2'd2;

  typedef struct packed {
    logic signed [SampleWidth-1:0] left_in;
    logic signed [SampleWidth-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] left_out;
    logic signed [SampleWidth-1:0] right_out;
    logic [GainWidth-1:0] applied_gain;
  } out_item_t;

  // What the front end hands the back end: delayed pair and classification.
  typedef struct packed {
    logic signed [SampleWidth-1:0] delayed_left;
    logic signed [SampleWidth-1:0] delayed_right;
    logic [SampleWidth-1:0] peak;
    logic [GainWidth-1:0] ceiling;
    logic over;
  } work_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_DIV, BK_REL, BK_MUL, BK_OUT
  } back_state_t;

endpackage

// File: rtl/slpl_front.sv
// Front end: writes the delay line, reads the lookahead pair and classifies the peak.
// Depends on slpl_pkg.
module slpl_front #(
  parameter int unsigned DELAY_DEPTH = slpl_pkg::DelayDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  slpl_pkg::in_item_t in_data,
  input  logic [23:0]        ceiling_gain,
  input  logic [9:0]         lookahead_samples,
  output logic               wk_valid,
  input  logic               wk_stall,
  output slpl_pkg::work_t    wk_data
);
  localparam int unsigned AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int unsigned LW = (AW > 10) ? AW : 10;
  localparam logic [LW-1:0] MaxLa = LW'(DELAY_DEPTH - 1);
  localparam logic [LW:0] DepthExt = (LW+1)'(DELAY_DEPTH);

  typedef enum logic [1:0] {FR_CLR, FR_IDLE, FR_READ, FR_HOLD} front_state_t;

  logic [47:0] mem [DELAY_DEPTH];
  logic [47:0] rd_data;
  front_state_t state, state_next;
  logic [AW-1:0] wp, rp, clr_addr;
  logic [LW-1:0] la;
  logic [LW:0] wp_ext, la_ext;
  logic [23:0] cur_peak, mag_l, mag_r, ceil_q;
  logic over_q;
  logic accept;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != FR_IDLE);

  // Clamp the lookahead and compute the read address, wrapping modulo the depth.
  always_comb begin
    la = LW'(lookahead_samples);
    if (la > MaxLa) la = MaxLa;
    wp_ext = (LW+1)'(wp);
    la_ext = {1'b0, la};
    if (wp_ext >= la_ext) begin
      rp = AW'(wp_ext - la_ext);
    end else begin
      rp = AW'(wp_ext + DepthExt - la_ext);
    end
    mag_l = in_data.left_in[23] ? 24'(-in_data.left_in) : in_data.left_in;
    mag_r = in_data.right_in[23] ? 24'(-in_data.right_in) : in_data.right_in;
  end

  // Delay memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (state == FR_CLR) begin
      mem[clr_addr] <= '0;
    end else if (accept) begin
      mem[wp] <= {in_data.left_in, in_data.right_in};
    end
    if (state == FR_READ) begin
      rd_data <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_CLR;
      wp <= '0;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == FR_CLR) clr_addr <= clr_addr + 1'b1;
      if (state == FR_READ) wp <= (wp == AW'(DELAY_DEPTH - 1)) ? '0 : wp + 1'b1;
    end
  end

  // Classification is registered on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_peak <= (mag_r > mag_l) ? mag_r : mag_l;
      ceil_q <= (ceiling_gain > slpl_pkg::UnityGain) ? slpl_pkg::UnityGain : ceiling_gain;
    end
  end
  assign over_q = cur_peak > ceil_q;

  always_comb begin
    state_next = state;
    wk_valid = 1'b0;
    unique case (state)
      FR_CLR: if (clr_addr == AW'(DELAY_DEPTH - 1)) state_next = FR_IDLE;
      FR_IDLE: if (accept) state_next = FR_READ;
      FR_READ: state_next = FR_HOLD;
      FR_HOLD: begin
        wk_valid = 1'b1;
        if (!wk_stall) state_next = FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  assign wk_data.delayed_left = rd_data[47:24];
  assign wk_data.delayed_right = rd_data[23:0];
  assign wk_data.peak = cur_peak;
  assign wk_data.ceiling = ceil_q;
  assign wk_data.over = over_q;
endmodule

// File: rtl/slpl_queue.sv
// Two-entry queue between the front and back ends.
// Depends on slpl_pkg.
module slpl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_stall,
  input  slpl_pkg::work_t wr_data,
  output logic            rd_valid,
  input  logic            rd_stall,
  output slpl_pkg::work_t rd_data
);
  slpl_pkg::work_t slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop;

  assign push = wr_valid && !wr_stall;
  assign pop = rd_valid && !rd_stall;
  assign wr_stall = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: rtl/slpl_back.sv
// Back end: restoring divider for the target gain, release step and gain multiply.
// Depends on slpl_pkg.
module slpl_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                wk_valid,
  output logic                wk_stall,
  input  slpl_pkg::work_t     wk_data,
  input  logic [23:0]         release_rate,
  output logic                out_valid,
  input  logic                out_stall,
  output slpl_pkg::out_item_t out_data
);
  slpl_pkg::back_state_t state, state_next;
  slpl_pkg::work_t job;
  logic [47:0] rem;
  logic [23:0] quo, divisor;
  logic [5:0] cnt;
  logic [23:0] gain, target;
  logic [48:0] trial;
  logic [47:0] rel_prod;
  logic signed [48:0] pl, pr;
  logic signed [48:0] ql, qr;
  logic take;

  assign take = wk_valid && !wk_stall;
  assign wk_stall = (state != slpl_pkg::BK_IDLE);
  assign out_valid = (state == slpl_pkg::BK_OUT);
  assign trial = {rem[47:0], 1'b0} - {25'd0, divisor};

  // Release product; it is used only where target is not below gain, so the difference is then non-negative.
  assign rel_prod = release_rate * (target - gain);

  always_comb begin
    ql = pl >>> 23;
    qr = pr >>> 23;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slpl_pkg::BK_IDLE;
      gain <= slpl_pkg::UnityGain;
      cnt <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        slpl_pkg::BK_IDLE: begin
          if (take) begin
            job <= wk_data;
            rem <= {24'd0, wk_data.ceiling};
            divisor <= wk_data.peak;
            quo <= '0;
            cnt <= 6'd0;
          end
        end
        slpl_pkg::BK_DIV: begin
          // One quotient bit a cycle of ceiling * 2^23 / peak.
          if (!trial[48]) begin
            rem <= trial[47:0];
            quo <= {quo[22:0], 1'b1};
          end else begin
            rem <= {rem[46:0], 1'b0};
            quo <= {quo[22:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
        end
        slpl_pkg::BK_REL: begin
          if (target < gain) begin
            gain <= target;
          end else if (24'(gain + rel_prod[47:24]) > slpl_pkg::UnityGain) begin
            gain <= slpl_pkg::UnityGain;
          end else begin
            gain <= gain + rel_prod[47:24];
          end
        end
        slpl_pkg::BK_MUL: begin
          pl <= 49'(job.delayed_left) * $signed({25'd0, gain});
          pr <= 49'(job.delayed_right) * $signed({25'd0, gain});
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    target = job.over ? quo : slpl_pkg::UnityGain;
  end

  // The divider runs 23 steps, one for each fraction bit of the gain.
  always_comb begin
    state_next = state;
    unique case (state)
      slpl_pkg::BK_IDLE: if (take) state_next = slpl_pkg::BK_DIV;
      slpl_pkg::BK_DIV: if (cnt == 6'd22) state_next = slpl_pkg::BK_REL;
      slpl_pkg::BK_REL: state_next = slpl_pkg::BK_MUL;
      slpl_pkg::BK_MUL: state_next = slpl_pkg::BK_OUT;
      slpl_pkg::BK_OUT: if (!out_stall) state_next = slpl_pkg::BK_IDLE;
      default: state_next = slpl_pkg::BK_IDLE;
    endcase
  end

  assign out_data.left_out = ql[23:0];
  assign out_data.right_out = qr[23:0];
  assign out_data.applied_gain = gain;
endmodule

// File: rtl/stereo_lookahead_peak_limiter_core.sv
// Stereo lookahead peak limiter, top level.
// The front end takes a new item only after the last one has been handed to the queue, and
// the back end only after its result, computed by the 23-step restoring divider, has left;
// so neither end takes a new item before it is through with the last one.
// Reset is synchronous; afterwards every word of the delay memory is cleared, and no item
// is accepted until the clear is done. Gain resets to unity.
module stereo_lookahead_peak_limiter_core #(
  parameter int unsigned DELAY_DEPTH = slpl_pkg::DelayDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  slpl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output slpl_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  logic [23:0] ceiling_gain, release_rate;
  logic [9:0] lookahead_samples;
  logic fq_valid, fq_stall, qb_valid, qb_stall;
  slpl_pkg::work_t fq_data, qb_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling_gain <= slpl_pkg::UnityGain;
      lookahead_samples <= '0;
      release_rate <= slpl_pkg::ReleaseReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slpl_pkg::RegCeiling: ceiling_gain <= cfg_data;
        slpl_pkg::RegLookahead: lookahead_samples <= cfg_data[9:0];
        slpl_pkg::RegRelease: release_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  slpl_front #(.DELAY_DEPTH(DELAY_DEPTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .ceiling_gain, .lookahead_samples,
    .wk_valid(fq_valid), .wk_stall(fq_stall), .wk_data(fq_data)
  );

  slpl_queue u_queue (
    .clk, .rst, .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_stall(qb_stall), .rd_data(qb_data)
  );

  slpl_back u_back (
    .clk, .rst, .wk_valid(qb_valid), .wk_stall(qb_stall), .wk_data(qb_data),
    .release_rate, .out_valid, .out_stall, .out_data
  );
endmodule

// File: rtl/slpl_checker.sv
// Port checker for the limiter top level, attached by bind.
// Depends on slpl_pkg.
module slpl_port_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input slpl_pkg::out_item_t out_data
);
  // The applied gain of a valid result never exceeds unity.
  a_gain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.applied_gain <= slpl_pkg::UnityGain) else $error("gain above unity");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result changed");

  // Checks that out_valid does not rise in the cycle after an accepted input.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid)) else $error("result too early");

  // The block accepts nothing in the cycle after reset.
  a_clr: assert property (@(posedge clk) $fell(rst) |-> in_stall) else $error("early accept");
endmodule

bind stereo_lookahead_peak_limiter_core slpl_port_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
